// ===== rtl/core/pid_windowed_integral_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the windowed-integral PID block
// Concurrent checks that are compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef PID_WINDOWED_INTEGRAL_TOP_MACROS_SVH
`define PID_WINDOWED_INTEGRAL_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define PWI_ASSERT(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
`define PWI_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define PWI_ASSERT(lbl, clk, rstn, cond, msg)
`define PWI_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif

`endif

// ===== rtl/core/pwi_pkg.sv =====
// ----------------------------------------------------------------------------
// pwi_pkg
// Shared constants and types of the windowed-integral PID block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pwi_pkg;

  localparam int unsigned WINDOW_LEN_DEF = 16;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned DATA_W         = 16;
  localparam int unsigned MAG_W          = 26;
  localparam int unsigned DERIV_W        = 27;
  localparam int unsigned PROD_W         = 43;
  localparam int unsigned ACC_W          = 48;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned MS_PER_S       = 1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP  = 2'd0,
    CFG_DERIV = 2'd1,
    CFG_INTEG = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] prop;
    logic signed [DATA_W-1:0] deriv;
    logic signed [DATA_W-1:0] integ;
  } gains_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] err;
    logic                     neg;
    logic [MAG_W-1:0]         mag;
    logic [DATA_W-1:0]        ms;
    logic                     zero;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/core/pid_windowed_integral_top.sv =====
// ----------------------------------------------------------------------------
// pid_windowed_integral_top
// PID controller for a zero target with an integral over a sliding window.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i)
//   writes the Q8.8 gains: index 0 proportional, 1 derivative, 2 integral.
//   Other indexes are ignored. The channel is always ready; write gains
//   only while no item is in flight.
//   Input channel (in_valid_i/in_ready_o) takes a signed reading and the
//   milliseconds since the previous one. Output channel
//   (out_valid_o/out_ready_i) returns one drive value and the zero-interval
//   flag per item, in order.
//   Each item passes the queue, the window update, the one-bit-per-cycle
//   divider (26 steps, skipped when the interval is zero) and the shared
//   multiplier used three times. Items are worked one at a time, so the
//   back end takes no new item until the result of the last is loaded.
//   A two-entry queue keeps taking items until it is full while the back
//   end works or the receiver stalls; the result is held in the output
//   register until taken. Reset clears the gains, the previous reading,
//   the error window and its sum; the window needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pid_windowed_integral_top_macros.svh"

module pid_windowed_integral_top #(
  parameter int unsigned WINDOW_LEN = pwi_pkg::WINDOW_LEN_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pwi_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [pwi_pkg::DATA_W-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [pwi_pkg::DATA_W-1:0]    sensor_value_i,
  input  logic [pwi_pkg::DATA_W-1:0]           elapsed_ms_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [31:0]                   drive_o,
  output logic                                 zero_interval_o
);

  pwi_pkg::gains_t  gains_q;
  pwi_pkg::q_stat_t q_stat;
  pwi_pkg::work_t   q_in;
  pwi_pkg::work_t   q_out;
  logic             q_push;
  logic             q_pop;
  logic [2:0]       inflight_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        pwi_pkg::CFG_PROP:  gains_q.prop  <= cfg_data_i;
        pwi_pkg::CFG_DERIV: gains_q.deriv <= cfg_data_i;
        pwi_pkg::CFG_INTEG: gains_q.integ <= cfg_data_i;
        default:            gains_q       <= gains_q;
      endcase
    end
  end

  pwi_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sensor_value_i (sensor_value_i),
    .elapsed_ms_i   (elapsed_ms_i),
    .q_stat_i       (q_stat),
    .q_push_o       (q_push),
    .q_data_o       (q_in)
  );

  pwi_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .pop_i  (q_pop),
    .data_o (q_out),
    .stat_o (q_stat)
  );

  pwi_back #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .gains_i         (gains_q),
    .q_stat_i        (q_stat),
    .q_data_i        (q_out),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_o         (drive_o),
    .zero_interval_o (zero_interval_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      case ({in_valid_i && in_ready_o, out_valid_o && out_ready_i})
        2'b10:   inflight_q <= inflight_q + 1'b1;
        2'b01:   inflight_q <= inflight_q - 1'b1;
        default: inflight_q <= inflight_q;
      endcase
    end
  end

  `PWI_ASSERT(a_pop_nonempty, clk_i, rst_ni, !(q_pop && q_stat.empty), "pop from empty queue")
  `PWI_ASSERT(a_inflight_bound, clk_i, rst_ni, inflight_q <= 3'd4, "too many items in flight")
  `PWI_ASSERT(a_out_has_item, clk_i, rst_ni, !out_valid_o || (inflight_q != 3'd0), "result without item")
  `PWI_ASSERT_NEXT(a_push_counts, clk_i, rst_ni, q_push && !(out_valid_o && out_ready_i), inflight_q == $past(inflight_q) + 3'd1, "accepted item not counted")

endmodule

// ===== rtl/core/pwi_front.sv =====
// ----------------------------------------------------------------------------
// pwi_front
// Accept readings, form the saturated error and the scaled reading change.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwi_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [pwi_pkg::DATA_W-1:0]   sensor_value_i,
  input  logic [pwi_pkg::DATA_W-1:0]          elapsed_ms_i,
  input  pwi_pkg::q_stat_t                    q_stat_i,
  output logic                                q_push_o,
  output pwi_pkg::work_t                      q_data_o
);

  logic signed [pwi_pkg::DATA_W-1:0]  last_q;
  logic signed [pwi_pkg::DATA_W:0]    delta;
  logic signed [pwi_pkg::DERIV_W-1:0] scaled;
  logic signed [pwi_pkg::DERIV_W-1:0] scaled_abs;

  assign in_ready_o = !q_stat_i.full;
  assign q_push_o   = in_valid_i && in_ready_o;

  always_comb begin
    delta      = (pwi_pkg::DATA_W+1)'(sensor_value_i) - (pwi_pkg::DATA_W+1)'(last_q);
    scaled     = pwi_pkg::DERIV_W'(delta) *
                 $signed(pwi_pkg::DERIV_W'(pwi_pkg::MS_PER_S));
    scaled_abs = scaled[pwi_pkg::DERIV_W-1] ? -scaled : scaled;
    if (sensor_value_i == {1'b1, {(pwi_pkg::DATA_W-1){1'b0}}}) begin
      q_data_o.err = {1'b0, {(pwi_pkg::DATA_W-1){1'b1}}};
    end else begin
      q_data_o.err = -sensor_value_i;
    end
    q_data_o.neg  = scaled[pwi_pkg::DERIV_W-1];
    q_data_o.mag  = scaled_abs[pwi_pkg::MAG_W-1:0];
    q_data_o.ms   = elapsed_ms_i;
    q_data_o.zero = (elapsed_ms_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (q_push_o) begin
      last_q <= sensor_value_i;
    end
  end

endmodule

// ===== rtl/core/pwi_queue.sv =====
// ----------------------------------------------------------------------------
// pwi_queue
// Short FIFO of work items between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwi_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pwi_pkg::work_t   data_i,
  input  logic             pop_i,
  output pwi_pkg::work_t   data_o,
  output pwi_pkg::q_stat_t stat_o
);

  localparam int unsigned PTR_W = (pwi_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(pwi_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(pwi_pkg::QUEUE_DEPTH + 1);

  pwi_pkg::work_t   slot_q [pwi_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q;
  logic [PTR_W-1:0] rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push;
  logic             do_pop;

  assign stat_o.full  = (cnt_q == CNT_W'(pwi_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(pwi_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(pwi_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/core/pwi_back.sv =====
// ----------------------------------------------------------------------------
// pwi_back
// Update the error window, divide, multiply-accumulate and saturate the drive.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwi_back #(
  parameter int unsigned WINDOW_LEN = pwi_pkg::WINDOW_LEN_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pwi_pkg::gains_t                   gains_i,
  input  pwi_pkg::q_stat_t                  q_stat_i,
  input  pwi_pkg::work_t                    q_data_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [31:0]                drive_o,
  output logic                              zero_interval_o
);

  localparam int unsigned SUM_W = pwi_pkg::DATA_W + $clog2(WINDOW_LEN);
  localparam int unsigned PW    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned DW    = pwi_pkg::DATA_W;
  localparam int unsigned CW    = $clog2(pwi_pkg::MAG_W);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RING = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL  = 6'b001000,
    S_ACC  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    SEL_PROP  = 2'd0,
    SEL_INTEG = 2'd1,
    SEL_DERIV = 2'd2
  } mul_sel_e;

  state_e                              state_q;
  pwi_pkg::work_t                      cur_q;
  logic signed [DW-1:0]                ring_mem [WINDOW_LEN];
  logic signed [DW-1:0]                rd_q;
  logic [WINDOW_LEN-1:0]               vld_q;
  logic [PW-1:0]                       pos_q;
  logic signed [SUM_W-1:0]             sum_q;
  logic [DW:0]                         rem_q;
  logic [pwi_pkg::MAG_W-1:0]           quo_q;
  logic [CW-1:0]                       cnt_q;
  mul_sel_e                            sel_q;
  logic signed [pwi_pkg::PROD_W-1:0]   prod_q;
  logic signed [pwi_pkg::ACC_W-1:0]    acc_q;
  logic                                out_valid_q;
  logic signed [31:0]                  drive_q;
  logic                                zero_q;

  logic signed [DW-1:0]                old_err;
  logic signed [SUM_W-1:0]             new_sum;
  logic [DW:0]                         rem_sh;
  logic                                rem_ge;
  logic [DW:0]                         rem_nx;
  logic signed [pwi_pkg::DERIV_W-1:0]  deriv;
  logic signed [DW-1:0]                mul_a;
  logic signed [pwi_pkg::DERIV_W-1:0]  mul_b;
  logic signed [pwi_pkg::PROD_W-1:0]   prod_d;
  logic signed [31:0]                  sat;
  logic                                ring_re;
  logic                                ring_we;
  logic                                out_load;

  assign ring_re  = (state_q == S_IDLE) && !q_stat_i.empty;
  assign ring_we  = (state_q == S_RING);
  assign q_pop_o  = ring_re;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  assign out_valid_o     = out_valid_q;
  assign drive_o         = drive_q;
  assign zero_interval_o = zero_q;

  always_comb begin
    old_err = vld_q[pos_q] ? rd_q : '0;
    new_sum = sum_q + SUM_W'(cur_q.err) - SUM_W'(old_err);
    rem_sh  = {rem_q[DW-1:0], quo_q[pwi_pkg::MAG_W-1]};
    rem_ge  = (rem_sh >= {1'b0, cur_q.ms});
    rem_nx  = rem_ge ? rem_sh - {1'b0, cur_q.ms} : rem_sh;
    if (cur_q.zero) begin
      deriv = '0;
    end else if (cur_q.neg) begin
      deriv = -$signed({1'b0, quo_q});
    end else begin
      deriv = $signed({1'b0, quo_q});
    end
    case (sel_q)
      SEL_PROP: begin
        mul_a = gains_i.prop;
        mul_b = pwi_pkg::DERIV_W'(cur_q.err);
      end
      SEL_INTEG: begin
        mul_a = gains_i.integ;
        mul_b = pwi_pkg::DERIV_W'(sum_q);
      end
      SEL_DERIV: begin
        mul_a = gains_i.deriv;
        mul_b = deriv;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
    if (!acc_q[pwi_pkg::ACC_W-1] && (|acc_q[pwi_pkg::ACC_W-2:31])) begin
      sat = 32'sh7fff_ffff;
    end else if (acc_q[pwi_pkg::ACC_W-1] && !(&acc_q[pwi_pkg::ACC_W-2:31])) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = acc_q[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[pos_q] <= cur_q.err;
    end
    if (ring_re) begin
      rd_q <= ring_mem[pos_q];
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (!q_stat_i.empty) begin
          cur_q <= q_data_i;
        end
      end
      S_RING: begin
        rem_q <= '0;
        quo_q <= cur_q.mag;
        cnt_q <= '0;
        sel_q <= SEL_PROP;
        acc_q <= '0;
      end
      S_DIV: begin
        rem_q <= rem_nx;
        quo_q <= {quo_q[pwi_pkg::MAG_W-2:0], rem_ge};
        cnt_q <= cnt_q + 1'b1;
      end
      S_MUL: begin
        prod_q <= prod_d;
      end
      S_ACC: begin
        acc_q <= acc_q + pwi_pkg::ACC_W'(prod_q);
        case (sel_q)
          SEL_PROP:  sel_q <= SEL_INTEG;
          SEL_INTEG: sel_q <= SEL_DERIV;
          default:   sel_q <= SEL_PROP;
        endcase
      end
      default: begin
      end
    endcase
    if (out_load) begin
      drive_q <= sat;
      zero_q  <= cur_q.zero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vld_q       <= '0;
      pos_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!q_stat_i.empty) begin
            state_q <= S_RING;
          end
        end
        S_RING: begin
          vld_q[pos_q] <= 1'b1;
          sum_q        <= new_sum;
          pos_q        <= (pos_q == PW'(WINDOW_LEN - 1)) ? '0 : pos_q + 1'b1;
          state_q      <= cur_q.zero ? S_MUL : S_DIV;
        end
        S_DIV: begin
          if (cnt_q == CW'(pwi_pkg::MAG_W - 1)) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          state_q <= (sel_q == SEL_DERIV) ? S_OUT : S_MUL;
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
